// ===== rtl/core/apq_pkg.sv =====
// apq_pkg: types and codes shared by the priority queue cells and top level.
// No dependencies.
`timescale 1ns / 1ps

package apq_pkg;

    // Operation codes carried in the operation field
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // One input transaction
    typedef struct packed {
        logic               operation;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_value;
        logic signed [15:0] out_priority;
        logic        [4:0]  entry_count;
        logic               is_empty;
        logic               is_full;
    } t_out_item;

    // One stored entry
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_cmd;

endpackage

// ===== rtl/core/apq_cell.sv =====
// apq_cell: one slot of the sorted shift chain of the priority queue.
// Depends on apq_pkg (t_entry, t_cell_cmd).
`timescale 1ns / 1ps

module apq_cell
    import apq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_occ,
    input  t_entry    i_new,
    input  logic      i_prev_ins,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output logic      o_ins,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // Insert at or before this slot when it is free or the new priority is strictly higher;
    // equal priorities stay ahead so arrival order breaks ties
    assign o_ins = !i_occ || ($signed(i_new.prio) > $signed(r_entry.prio));

    // Take the new entry at the insert point, shift down behind it, shift up on removal
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq && o_ins) begin
            n_entry = i_prev_ins ? i_prev : i_new;
        end else if (i_cmd.deq) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/array_priority_queue.sv =====
// A result is registered and presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while results are taken at once; every cell of the
// sorted chain updates together. A result left waiting holds off the input until
// the cycle in which it is taken.
// Reset: clears the entry count and the output valid; cell contents are not cleared.
// array_priority_queue: top level; instantiates DEPTH apq_cell slots, uses apq_pkg.
`timescale 1ns / 1ps

module array_priority_queue
    import apq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    t_out_item       r_out;
    t_out_item       n_out;
    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    logic            w_enq_do;
    logic            w_deq_do;
    t_cell_cmd       w_cmd;
    t_entry          w_new;
    t_entry          w_entry [DEPTH];
    logic [DEPTH-1:0] w_ins;
    logic [CW+4:0]   w_cnt_ext;

    // Handshake and command decode
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == FULL_CNT);
    assign w_empty    = (r_count == '0);
    assign w_enq_do   = w_accept && (i_in_data.operation == OP_ENQUEUE) && !w_full;
    assign w_deq_do   = w_accept && (i_in_data.operation == OP_DEQUEUE) && !w_empty;
    assign w_cmd.enq  = w_enq_do;
    assign w_cmd.deq  = w_deq_do;
    assign w_new.value = i_in_data.item_value;
    assign w_new.prio  = i_in_data.item_priority;

    // Chain of cells, kept sorted by priority, highest at the head
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic   w_occ;
        logic   w_prev_ins;
        t_entry w_prev;
        t_entry w_next;

        assign w_occ = (r_count > CW'(gi));

        if (gi == 0) begin : g_head
            assign w_prev_ins = 1'b0;
            assign w_prev     = w_new;
        end else begin : g_body
            assign w_prev_ins = w_ins[gi-1];
            assign w_prev     = w_entry[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_entry[gi+1];
        end

        apq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_occ      (w_occ),
            .i_new      (w_new),
            .i_prev_ins (w_prev_ins),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_ins      (w_ins[gi]),
            .o_entry    (w_entry[gi])
        );
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (w_enq_do) begin
            n_count = r_count + 1'b1;
        end else if (w_deq_do) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_cnt_ext = {5'd0, n_count};

    // Build the result for the accepted transaction
    always_comb begin
        n_out              = '0;
        n_out.status       = ST_OK;
        n_out.entry_count  = w_cnt_ext[4:0];
        n_out.is_empty     = (n_count == '0);
        n_out.is_full      = (n_count == FULL_CNT);
        if (i_in_data.operation == OP_ENQUEUE) begin
            if (w_full) begin
                n_out.status = ST_OVERFLOW;
            end
        end else begin
            if (w_empty) begin
                n_out.status = ST_UNDERFLOW;
            end else begin
                n_out.out_value    = w_entry[0].value;
                n_out.out_priority = w_entry[0].prio;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Count stays within the chain
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds depth");

    // Overflow leaves the count unchanged
    a_overflow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.operation == OP_ENQUEUE) && w_full) |=> $stable(r_count))
        else $error("count changed on overflow");

    // Successful dequeue removes exactly one entry
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deq_do |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not decrement count");

    // Head of the chain holds a priority no lower than the second entry
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |->
            ($signed(w_entry[0].prio) >= $signed(w_entry[1].prio)))
        else $error("chain head out of priority order");

    // Every accepted transaction produces a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

endmodule

// ===== verif/tb_array_priority_queue.sv =====
// tb_array_priority_queue: self-checking testbench for the bounded priority queue.
// Drives random and directed transactions, predicts each result with a shadow queue;
// depends on apq_pkg and array_priority_queue.
`timescale 1ns / 1ps

module tb_array_priority_queue;
    import apq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    // Shadow copy of the queue contents, in arrival order
    logic signed [31:0] shadow_vals [DEPTH];
    logic signed [15:0] shadow_pris [DEPTH];
    int                 shadow_count = 0;

    t_out_item pending_results [$];
    int        error_count     = 0;
    int        cycle_count     = 0;
    int        rx_hold_req     = 0;
    bit        tx_back_to_back = 1'b0;

    array_priority_queue #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Priority: mostly a narrow band to force ties, sometimes extremes or full range
    function automatic logic signed [15:0] pick_priority();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 16'(int'($urandom_range(0, 8)) - 4);
        else if (roll < 80)
            return 16'($urandom);
        else if (roll < 90)
            return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        return ($urandom_range(0, 1) != 0) ? 16'sh7ffe : 16'sh8001;
    endfunction

    function automatic t_in_item make_item(input logic op, input logic signed [31:0] val,
                                           input logic signed [15:0] pri);
        t_in_item item;
        item.operation     = op;
        item.item_value    = val;
        item.item_priority = pri;
        return item;
    endfunction

    // Apply one operation to the shadow queue and return the result it must produce
    function automatic t_out_item serve_queue_op(input t_in_item item);
        t_out_item res;
        int        best;
        int        i;
        res        = '0;
        res.status = ST_OK;
        if (item.operation == OP_ENQUEUE) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                shadow_vals[shadow_count] = item.item_value;
                shadow_pris[shadow_count] = item.item_priority;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            res.status = ST_UNDERFLOW;
        end else begin
            // Strict compare keeps the earliest of equal priorities
            best = 0;
            for (i = 1; i < shadow_count; i++) begin
                if (shadow_pris[i] > shadow_pris[best])
                    best = i;
            end
            res.out_value    = shadow_vals[best];
            res.out_priority = shadow_pris[best];
            // Close the gap, keeping arrival order
            for (i = best; i + 1 < shadow_count; i++) begin
                shadow_vals[i] = shadow_vals[i + 1];
                shadow_pris[i] = shadow_pris[i + 1];
            end
            shadow_count--;
        end
        res.entry_count = 5'(shadow_count);
        res.is_empty    = (shadow_count == 0);
        res.is_full     = (shadow_count >= DEPTH);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Offer one transaction; called and returns at a falling edge
    task automatic send_queue_op(input t_in_item item);
        int gap;
        gap = 0;
        if (!tx_back_to_back && $urandom_range(0, 99) >= 55)
            gap = pick_idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        pending_results.push_back(serve_queue_op(item));
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_queue_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, steady stretches, and a long hold-off on request
    initial begin
        int stall_left;
        int steady_left;
        int roll;
        out_ready   = 1'b0;
        stall_left  = 0;
        steady_left = 0;
        forever begin
            @(negedge clk);
            if (rx_hold_req != 0) begin
                stall_left  = rx_hold_req;
                steady_left = 0;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (steady_left > 0) begin
                out_ready <= 1'b1;
                steady_left--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    steady_left = $urandom_range(30, 80);
                    out_ready   <= 1'b1;
                end else if (roll < 30) begin
                    stall_left = pick_idle_len() - 1;
                    out_ready  <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Compare each result transaction against the oldest prediction
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", out_data));
            end else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_data.status, want.status));
                if (out_data.out_value !== want.out_value)
                    report_mismatch($sformatf("out_value got %h want %h",
                                              out_data.out_value, want.out_value));
                if (out_data.out_priority !== want.out_priority)
                    report_mismatch($sformatf("out_priority got %h want %h",
                                              out_data.out_priority, want.out_priority));
                if (out_data.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              out_data.entry_count, want.entry_count));
                if (out_data.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty got %b want %b",
                                              out_data.is_empty, want.is_empty));
                if (out_data.is_full !== want.is_full)
                    report_mismatch($sformatf("is_full got %b want %b",
                                              out_data.is_full, want.is_full));
            end
        end
    end

    // Underflow, extreme fields, ties on top priority and bottom priority
    task automatic test_corner_cases();
        send_queue_op(make_item(OP_DEQUEUE, 32'shffff_ffff, 16'shffff));
        send_queue_op(make_item(OP_ENQUEUE, 32'sh8000_0000, 16'sh8000));
        send_queue_op(make_item(OP_ENQUEUE, 32'sh7fff_ffff, 16'sh7fff));
        send_queue_op(make_item(OP_ENQUEUE, 32'sh0000_0000, 16'sh0000));
        send_queue_op(make_item(OP_ENQUEUE, 32'sh0000_0001, 16'sh7fff));
        send_queue_op(make_item(OP_ENQUEUE, 32'shffff_ffff, 16'sh8000));
        send_queue_op(make_item(OP_ENQUEUE, 32'sh5555_aaaa, 16'sh0000));
        send_queue_op(make_item(OP_DEQUEUE, 32'sh1234_5678, 16'sh7fff));
        send_queue_op(make_item(OP_DEQUEUE, 32'shffff_ffff, 16'sh8000));
        send_queue_op(make_item(OP_DEQUEUE, 32'sh0000_0000, 16'sh0000));
        send_queue_op(make_item(OP_DEQUEUE, 32'shaaaa_5555, 16'sh5555));
        send_queue_op(make_item(OP_DEQUEUE, 32'sh7fff_ffff, 16'shaaaa));
        send_queue_op(make_item(OP_DEQUEUE, 32'sh8000_0000, 16'sh0001));
        send_queue_op(make_item(OP_DEQUEUE, 32'shdead_beef, 16'sh7fff));
        send_queue_op(make_item(OP_ENQUEUE, 32'shdead_beef, 16'sh7ffe));
        send_queue_op(make_item(OP_DEQUEUE, 32'sh0000_0000, 16'sh0000));
    endtask

    // Fill to capacity, push past it, then empty it and pop past empty
    task automatic test_fill_and_overflow();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_queue_op(make_item(OP_ENQUEUE, $urandom, 16'(int'($urandom_range(0, 3)))));
        for (i = 0; i < 3; i++)
            send_queue_op(make_item(OP_ENQUEUE, $urandom, pick_priority()));
        for (i = 0; i < DEPTH + 2; i++)
            send_queue_op(make_item(OP_DEQUEUE, $urandom, pick_priority()));
    endtask

    // Hold the receiver off while the sender keeps offering back to back
    task automatic test_receiver_holdoff();
        int i;
        @(posedge clk);
        rx_hold_req = HOLD_CYCLES;
        @(negedge clk);
        tx_back_to_back = 1'b1;
        for (i = 0; i < 24; i++)
            send_queue_op(make_item((i < 18) ? OP_ENQUEUE : OP_DEQUEUE, $urandom,
                                    pick_priority()));
        tx_back_to_back = 1'b0;
    endtask

    // Bursts with varying enqueue bias so the fill level sweeps empty to full
    task automatic test_random_traffic(input int n_items);
        int       sent;
        int       burst_len;
        int       enq_pct;
        int       i;
        t_in_item item;
        sent = 0;
        while (sent < n_items) begin
            burst_len = $urandom_range(15, 40);
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 70;
                default: enq_pct = 90;
            endcase
            tx_back_to_back = ($urandom_range(0, 4) == 0);
            for (i = 0; i < burst_len && sent < n_items; i++) begin
                item.operation     = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE
                                                                       : OP_DEQUEUE;
                item.item_value    = $urandom;
                item.item_priority = pick_priority();
                send_queue_op(item);
                sent++;
            end
        end
        tx_back_to_back = 1'b0;
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        drain_queue_results();
        test_fill_and_overflow();
        drain_queue_results();
        test_receiver_holdoff();
        drain_queue_results();
        test_random_traffic(780);
        drain_queue_results();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
